// ===== hw/rtl/rbd_pkg.sv =====
// ============================================================================
// rbd_pkg: shared types and constants of the record block deframer
// Holds the parse phases, the field scanner state, result item layout and
// the codes carried on the result stream.
// ============================================================================
package rbd_pkg;

    // Field character position counter; fields are at most eight characters.
    localparam int IDX_W = 4;

    // Width of decoded numeric fields and of the result payload parts.
    localparam int VAL_W   = 28;
    localparam int COUNT_W = 15;
    localparam int RECS_W  = 14;

    // Depth of the result queue; two free entries are needed per byte.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_PRED,
        PH_SUCC,
        PH_LEN,
        PH_TEXT,
        PH_IDLE,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        SCAN_SPACE,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_DONE,
        SCAN_FAIL
    } scan_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_CORRUPT = 2'd2
    } status_t;

    typedef struct packed {
        scan_t             scan;
        logic              neg;
        logic              all_f;
        logic [VAL_W-1:0]  value;
    } field_t;

    localparam field_t FIELD_START = '{
        scan:  SCAN_SPACE,
        neg:   1'b0,
        all_f: 1'b1,
        value: '0
    };

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data_byte;
        logic               record_last;
        logic [COUNT_W-1:0] record_count;
        logic [VAL_W-1:0]   pred_link;
        logic [VAL_W-1:0]   succ_link;
        status_t            status;
    } result_t;

    // Up to two results per byte: a record item first, then the status item.
    typedef struct packed {
        logic    rec_valid;
        result_t rec;
        logic    stat_valid;
        result_t stat;
    } push_t;

endpackage

// ===== hw/rtl/rbd_field_scan.sv =====
// ============================================================================
// rbd_field_scan: one character step of the ASCII number decoder
// Skips leading white space, takes an optional sign, then accumulates
// decimal digits until the first non-digit. Tracks an all-F field.
// ============================================================================
module rbd_field_scan
(
    input  logic [7:0]      ch,
    input  rbd_pkg::field_t cur,
    output rbd_pkg::field_t nxt
);

    logic is_digit;
    logic is_space;
    logic [rbd_pkg::VAL_W-1:0] times_ten;

    assign is_digit  = (ch >= rbd_pkg::CHAR_ZERO) && (ch <= rbd_pkg::CHAR_NINE);
    assign is_space  = (ch == rbd_pkg::CHAR_SPACE)
                    || ((ch >= rbd_pkg::CHAR_TAB) && (ch <= rbd_pkg::CHAR_CR));
    assign times_ten = (cur.value << 3) + (cur.value << 1);

    always_comb
    begin
        nxt = cur;
        if (ch != rbd_pkg::CHAR_F)
        begin
            nxt.all_f = 1'b0;
        end
        unique case (cur.scan)
            rbd_pkg::SCAN_SPACE:
            begin
                priority if (is_space)
                begin
                    nxt.scan = rbd_pkg::SCAN_SPACE;
                end
                else if (ch == rbd_pkg::CHAR_PLUS)
                begin
                    nxt.scan = rbd_pkg::SCAN_SIGN;
                end
                else if (ch == rbd_pkg::CHAR_MINUS)
                begin
                    nxt.neg  = 1'b1;
                    nxt.scan = rbd_pkg::SCAN_SIGN;
                end
                else if (is_digit)
                begin
                    nxt.value = rbd_pkg::VAL_W'(ch[3:0]);
                    nxt.scan  = rbd_pkg::SCAN_DIGITS;
                end
                else
                begin
                    nxt.scan = rbd_pkg::SCAN_FAIL;
                end
            end
            rbd_pkg::SCAN_SIGN:
            begin
                if (is_digit)
                begin
                    nxt.value = rbd_pkg::VAL_W'(ch[3:0]);
                    nxt.scan  = rbd_pkg::SCAN_DIGITS;
                end
                else
                begin
                    nxt.scan = rbd_pkg::SCAN_FAIL;
                end
            end
            rbd_pkg::SCAN_DIGITS:
            begin
                // Fields hold at most eight digits, so the sum cannot overflow.
                if (is_digit)
                begin
                    nxt.value = times_ten + rbd_pkg::VAL_W'(ch[3:0]);
                end
                else
                begin
                    nxt.scan = rbd_pkg::SCAN_DONE;
                end
            end
            default:
            begin
                nxt.scan = cur.scan;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rbd_parser.sv =====
// ============================================================================
// rbd_parser: block parse state and per-byte result generation
// Walks the header fields, the length prefixes and the record text of one
// block, and produces at most a record item and a status item per byte.
// ============================================================================
module rbd_parser
#(
    parameter int COUNT_CHARS     = 4,
    parameter int LINK_CHARS      = 8,
    parameter int LENGTH_CHARS    = 4,
    parameter int MAX_BLOCK_BYTES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           raw_byte,
    input  logic [12:0]          block_size,
    output rbd_pkg::push_t       push
);

    localparam int POS_W  = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int HDR    = COUNT_CHARS + 2 * LINK_CHARS;
    localparam int SAT_W  = 14;
    localparam int CHK_W  = rbd_pkg::VAL_W + 1;
    localparam logic [rbd_pkg::RECS_W-1:0] RECS_MAX = '1;

    logic [POS_W-1:0]            pos_reg, pos_next;
    rbd_pkg::phase_t             phase_reg, phase_next;
    logic [rbd_pkg::IDX_W-1:0]   idx_reg, idx_next;
    rbd_pkg::field_t             fld_reg, fld_next, fld_step;
    logic [rbd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [rbd_pkg::VAL_W-1:0]   pred_reg, pred_next;
    logic [rbd_pkg::VAL_W-1:0]   succ_reg, succ_next;
    logic [rbd_pkg::RECS_W-1:0]  recs_reg, recs_next;
    logic [POS_W-1:0]            text_reg, text_next;
    rbd_pkg::status_t            err_reg, err_next;

    logic [SAT_W-1:0]            size_sat;
    logic [POS_W-1:0]            size;
    logic [POS_W:0]              next_pos;
    logic                        block_end;
    logic                        len_fits;
    logic [rbd_pkg::IDX_W-1:0]   idx_inc;
    logic [rbd_pkg::IDX_W-1:0]   width_sel;
    logic                        fld_ok;
    logic [rbd_pkg::VAL_W-1:0]   fld_val;
    logic                        len_over;
    logic [rbd_pkg::RECS_W-1:0]  recs_sat;
    logic [rbd_pkg::RECS_W-1:0]  recs_dec;
    logic [POS_W-1:0]            text_dec;
    rbd_pkg::phase_t             nr_phase;

    // Phase after a record: idle when none are left, error when no room for
    // the next length prefix, otherwise read the next length prefix.
    function automatic rbd_pkg::phase_t after_record(
        input logic [rbd_pkg::RECS_W-1:0] left,
        input logic                       fits
    );
        rbd_pkg::phase_t ph;
        if (left == '0)
        begin
            ph = rbd_pkg::PH_IDLE;
        end
        else if (!fits)
        begin
            ph = rbd_pkg::PH_ERR;
        end
        else
        begin
            ph = rbd_pkg::PH_LEN;
        end
        return ph;
    endfunction

    rbd_field_scan u_scan
    (
        .ch  (raw_byte),
        .cur (fld_reg),
        .nxt (fld_step)
    );

    always_comb
    begin
        size_sat = {1'b0, block_size};
        if (size_sat > SAT_W'(MAX_BLOCK_BYTES))
        begin
            size_sat = SAT_W'(MAX_BLOCK_BYTES);
        end
        if (size_sat < SAT_W'(HDR))
        begin
            size_sat = SAT_W'(HDR);
        end
    end

    assign size      = POS_W'(size_sat);
    assign next_pos  = (POS_W + 1)'(pos_reg) + (POS_W + 1)'(1);
    assign block_end = next_pos >= (POS_W + 1)'(size);
    assign len_fits  = ((POS_W + 2)'(next_pos) + (POS_W + 2)'(LENGTH_CHARS))
                       <= (POS_W + 2)'(size);
    assign idx_inc   = idx_reg + rbd_pkg::IDX_W'(1);

    always_comb
    begin
        unique case (phase_reg)
            rbd_pkg::PH_COUNT: width_sel = rbd_pkg::IDX_W'(COUNT_CHARS);
            rbd_pkg::PH_LEN:   width_sel = rbd_pkg::IDX_W'(LENGTH_CHARS);
            default:           width_sel = rbd_pkg::IDX_W'(LINK_CHARS);
        endcase
    end

    // Decoded value of the field including this character, -1 when null.
    assign fld_ok  = !fld_step.all_f
                  && ((fld_step.scan == rbd_pkg::SCAN_DIGITS)
                   || (fld_step.scan == rbd_pkg::SCAN_DONE));
    assign fld_val = !fld_ok      ? '1
                   : fld_step.neg ? ('0 - fld_step.value)
                   :                fld_step.value;

    assign len_over = (CHK_W'(next_pos) + CHK_W'(fld_val[rbd_pkg::VAL_W-2:0]))
                      > CHK_W'(size);

    // Records to read: positive counts only, clipped far above what fits.
    assign recs_sat = (fld_val[rbd_pkg::VAL_W-1] || (fld_val == '0)) ? '0
                    : (|fld_val[rbd_pkg::VAL_W-2:rbd_pkg::RECS_W]) ? RECS_MAX
                    : fld_val[rbd_pkg::RECS_W-1:0];
    assign recs_dec = (recs_reg != '0) ? recs_reg - rbd_pkg::RECS_W'(1) : '0;
    assign text_dec = text_reg - POS_W'(1);

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        fld_next   = fld_reg;
        count_next = count_reg;
        pred_next  = pred_reg;
        succ_next  = succ_reg;
        recs_next  = recs_reg;
        text_next  = text_reg;
        err_next   = err_reg;
        nr_phase   = rbd_pkg::PH_IDLE;
        push       = '0;

        if (fire)
        begin
            unique case (phase_reg)
                rbd_pkg::PH_COUNT, rbd_pkg::PH_PRED, rbd_pkg::PH_SUCC, rbd_pkg::PH_LEN:
                begin
                    fld_next = fld_step;
                    idx_next = idx_inc;
                    if (idx_inc == width_sel)
                    begin
                        fld_next = rbd_pkg::FIELD_START;
                        idx_next = '0;
                        unique case (phase_reg)
                            rbd_pkg::PH_COUNT:
                            begin
                                count_next = fld_val[rbd_pkg::COUNT_W-1:0];
                                recs_next  = recs_sat;
                                phase_next = rbd_pkg::PH_PRED;
                            end
                            rbd_pkg::PH_PRED:
                            begin
                                pred_next  = fld_val;
                                phase_next = rbd_pkg::PH_SUCC;
                            end
                            rbd_pkg::PH_SUCC:
                            begin
                                succ_next  = fld_val;
                                nr_phase   = after_record(recs_reg, len_fits);
                                phase_next = nr_phase;
                            end
                            default:
                            begin
                                if (fld_val[rbd_pkg::VAL_W-1] || len_over)
                                begin
                                    err_next   = rbd_pkg::ST_CORRUPT;
                                    phase_next = rbd_pkg::PH_ERR;
                                end
                                else if (fld_val == '0)
                                begin
                                    push.rec_valid = 1'b1;
                                    push.rec.kind  = rbd_pkg::KIND_EMPTY;
                                    recs_next      = recs_dec;
                                    nr_phase       = after_record(recs_dec, len_fits);
                                    phase_next     = nr_phase;
                                end
                                else
                                begin
                                    text_next  = POS_W'(fld_val);
                                    phase_next = rbd_pkg::PH_TEXT;
                                end
                            end
                        endcase
                    end
                end
                rbd_pkg::PH_TEXT:
                begin
                    text_next             = text_dec;
                    push.rec_valid        = 1'b1;
                    push.rec.kind         = rbd_pkg::KIND_BYTE;
                    push.rec.data_byte    = raw_byte;
                    push.rec.record_last  = (text_dec == '0);
                    if (text_dec == '0)
                    begin
                        recs_next  = recs_dec;
                        nr_phase   = after_record(recs_dec, len_fits);
                        phase_next = nr_phase;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (nr_phase == rbd_pkg::PH_ERR)
            begin
                err_next = rbd_pkg::ST_TRUNC;
            end

            if (block_end)
            begin
                push.stat_valid        = 1'b1;
                push.stat.kind         = rbd_pkg::KIND_STATUS;
                push.stat.record_count = count_next;
                push.stat.pred_link    = pred_next;
                push.stat.succ_link    = succ_next;
                push.stat.status       = err_next;
                pos_next   = '0;
                phase_next = rbd_pkg::PH_COUNT;
                idx_next   = '0;
                fld_next   = rbd_pkg::FIELD_START;
                recs_next  = '0;
                text_next  = '0;
                err_next   = rbd_pkg::ST_OK;
            end
            else
            begin
                pos_next = POS_W'(next_pos);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= rbd_pkg::PH_COUNT;
            idx_reg   <= '0;
            fld_reg   <= rbd_pkg::FIELD_START;
            count_reg <= '0;
            pred_reg  <= '1;
            succ_reg  <= '1;
            recs_reg  <= '0;
            text_reg  <= '0;
            err_reg   <= rbd_pkg::ST_OK;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            fld_reg   <= fld_next;
            count_reg <= count_next;
            pred_reg  <= pred_next;
            succ_reg  <= succ_next;
            recs_reg  <= recs_next;
            text_reg  <= text_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== hw/rtl/rbd_out_queue.sv =====
// ============================================================================
// rbd_out_queue: small result queue between the parser and the output port
// Takes up to two results per cycle and hands one per transaction to the
// downstream side. Signals when two entries are free.
// ============================================================================
module rbd_out_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  rbd_pkg::push_t   push,
    output logic             room2,
    output logic             out_valid,
    input  logic             out_ready,
    output rbd_pkg::result_t out_item
);

    localparam int DEPTH = rbd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rbd_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic             push0;
    logic             push1;
    rbd_pkg::result_t item0;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [CNT_W-1:0] push_n;

    assign push0        = push.rec_valid || push.stat_valid;
    assign push1        = push.rec_valid && push.stat_valid;
    assign item0        = push.rec_valid ? push.rec : push.stat;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign push_n       = CNT_W'(push0) + CNT_W'(push1);

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room2     = (CNT_W'(DEPTH) - count_reg) >= CNT_W'(2);
    assign out_item  = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + push_n - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem[wr_ptr_reg] <= item0;
        end
        if (push1)
        begin
            mem[wr_ptr_plus1] <= push.stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    as_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue holds more entries than its depth");

    as_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push0 |-> (count_reg - CNT_W'(pop)) <= CNT_W'(DEPTH) - push_n)
        else $error("result pushed into a queue without room");

    as_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> push.stat.kind == rbd_pkg::KIND_STATUS
               && push.rec.kind != rbd_pkg::KIND_STATUS)
        else $error("second result of a byte is not the status item");

endmodule

// ===== hw/rtl/record_block_deframer.sv =====
// ============================================================================
// record_block_deframer: byte stream parser for fixed-size record blocks
// Decodes the ASCII header of each block and streams out the record text,
// empty-record markers and one status item per block.
// ============================================================================
// Usage:
// The slave stream (s_tvalid, s_tready, s_tdata) carries the bytes of each
// block in order, one byte per transaction. Blocks follow each other with no
// gap; the block length comes from the cfg channel (cfg_valid, cfg_ready,
// cfg_data), which is always ready and should be written only while idle.
// The master stream carries results: tuser gives the kind (record byte,
// empty record, end-of-block status), tlast flags the final byte of a record,
// and tdata carries the byte or the decoded header values and status.
// A byte is parsed once it sits in the input register and the result queue
// has two free entries; its results are written into that queue, which
// presents them in order on the master side. One byte is taken every cycle
// for as long as the result queue has two free entries; a block's last byte
// may produce two results, so a status item costs one extra output
// transaction per block.
// Reset clears the parse state to the start of a block, sets the block size
// to 512 and the link values to -1. When the receiver stalls, results wait in
// a four-entry queue; once fewer than two entries are free, the byte in the
// input register waits and s_tready stays low until it can be parsed.
// ============================================================================
module record_block_deframer
#(
    parameter int COUNT_CHARS     = 4,
    parameter int LINK_CHARS      = 8,
    parameter int LENGTH_CHARS    = 4,
    parameter int MAX_BLOCK_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_byte

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,  // [12:0] block_size

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] data_byte, [22:8] record_count,
                                   // [50:23] pred_link, [78:51] succ_link,
                                   // [80:79] status, [87:81] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // record_last
);

    localparam logic [12:0] BLOCK_SIZE_RESET = 13'd512;

    logic [12:0]      block_size_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             room2;
    logic             process;
    rbd_pkg::push_t   push;
    rbd_pkg::result_t out_item;

    // The configuration register takes every write on the cycle it arrives.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            block_size_reg <= cfg_data;
        end
    end

    // The input register holds one byte. It is parsed in the cycle after it
    // is taken, provided the queue can absorb both results it might cause;
    // a new byte enters the same cycle the held one is parsed.
    assign process  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    rbd_parser
    #(
        .COUNT_CHARS     (COUNT_CHARS),
        .LINK_CHARS      (LINK_CHARS),
        .LENGTH_CHARS    (LENGTH_CHARS),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    )
    u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (process),
        .raw_byte   (in_byte_reg),
        .block_size (block_size_reg),
        .push       (push)
    );

    rbd_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tdata = {7'd0,
                      out_item.status,
                      out_item.succ_link,
                      out_item.pred_link,
                      out_item.record_count,
                      out_item.data_byte};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.record_last;

    // A byte waiting in the input register is never dropped or changed.
    as_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !process |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte was lost or overwritten");

    // Only status items carry header values and status; others are zero there.
    as_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rbd_pkg::KIND_STATUS) |-> m_tdata[80:8] == '0)
        else $error("non-status result carries header fields");

    // Only record bytes may carry a last-of-record mark or a data byte.
    as_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rbd_pkg::KIND_BYTE) |-> !m_tlast && m_tdata[7:0] == '0)
        else $error("marker or status item carries record byte fields");

endmodule

// ===== tb/record_block_deframer_check.sv =====
// ============================================================================
// record_block_deframer_check: result predictor and comparator
// Watches the byte, configuration and result channels of the deframer, keeps
// its own copy of the parse state, and compares every result transaction in
// order with the results that the accepted bytes should have produced.
// ============================================================================
module record_block_deframer_check
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [12:0] cfg_data,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,

    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_CHARS     = 4;
    localparam int LINK_CHARS      = 8;
    localparam int LENGTH_CHARS    = 4;
    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int HEADER_BYTES    = COUNT_CHARS + 2 * LINK_CHARS;
    localparam int SIZE_AT_RESET   = 512;
    localparam int NULL_NUMBER     = -1;
    // Digits stop accumulating once the value reaches this bound.
    localparam int unsigned DIGIT_CAP = 100000000;

    logic [12:0]       blk_size;
    int unsigned       byte_pos;
    rbd_pkg::phase_t   parse_phase;
    int unsigned       char_idx;
    int unsigned       acc_value;
    logic              acc_all_f;
    rbd_pkg::scan_t    acc_scan;
    logic              acc_neg;
    int                hdr_count;
    int                hdr_pred;
    int                hdr_succ;
    int unsigned       recs_left;
    int unsigned       text_left;
    rbd_pkg::status_t  blk_status;

    rbd_pkg::result_t  awaited_items[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic int unsigned size_in_use();
        int unsigned sz;
        sz = blk_size;
        if (sz > MAX_BLOCK_BYTES)
            sz = MAX_BLOCK_BYTES;
        if (sz < HEADER_BYTES)
            sz = HEADER_BYTES;
        return sz;
    endfunction

    function automatic void begin_field();
        char_idx  = 0;
        acc_value = 0;
        acc_all_f = 1'b1;
        acc_scan  = rbd_pkg::SCAN_SPACE;
        acc_neg   = 1'b0;
    endfunction

    // Decimal scan in the style of a string-to-integer conversion.
    function automatic void scan_char(input logic [7:0] c);
        logic digit;
        logic blank;
        digit = (c >= rbd_pkg::CHAR_ZERO) && (c <= rbd_pkg::CHAR_NINE);
        blank = (c == rbd_pkg::CHAR_SPACE)
             || ((c >= rbd_pkg::CHAR_TAB) && (c <= rbd_pkg::CHAR_CR));
        if (c != rbd_pkg::CHAR_F)
            acc_all_f = 1'b0;
        case (acc_scan)
            rbd_pkg::SCAN_SPACE:
            begin
                if (blank)
                    acc_scan = rbd_pkg::SCAN_SPACE;
                else if (c == rbd_pkg::CHAR_PLUS)
                    acc_scan = rbd_pkg::SCAN_SIGN;
                else if (c == rbd_pkg::CHAR_MINUS)
                begin
                    acc_neg  = 1'b1;
                    acc_scan = rbd_pkg::SCAN_SIGN;
                end
                else if (digit)
                begin
                    acc_value = c - rbd_pkg::CHAR_ZERO;
                    acc_scan  = rbd_pkg::SCAN_DIGITS;
                end
                else
                    acc_scan = rbd_pkg::SCAN_FAIL;
            end
            rbd_pkg::SCAN_SIGN:
            begin
                if (digit)
                begin
                    acc_value = c - rbd_pkg::CHAR_ZERO;
                    acc_scan  = rbd_pkg::SCAN_DIGITS;
                end
                else
                    acc_scan = rbd_pkg::SCAN_FAIL;
            end
            rbd_pkg::SCAN_DIGITS:
            begin
                if (!digit)
                    acc_scan = rbd_pkg::SCAN_DONE;
                else if (acc_value < DIGIT_CAP)
                    acc_value = acc_value * 10 + (c - rbd_pkg::CHAR_ZERO);
            end
            default:
                acc_scan = acc_scan;
        endcase
    endfunction

    function automatic int field_number();
        if (acc_all_f || !(acc_scan == rbd_pkg::SCAN_DIGITS
                        || acc_scan == rbd_pkg::SCAN_DONE))
            return NULL_NUMBER;
        return acc_neg ? -int'(acc_value) : int'(acc_value);
    endfunction

    function automatic void push_result(input rbd_pkg::kind_t k, input logic [7:0] d,
                                        input logic l, input int cnt, input int pred,
                                        input int succ, input rbd_pkg::status_t st);
        rbd_pkg::result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.record_last  = l;
        r.record_count = cnt[rbd_pkg::COUNT_W-1:0];
        r.pred_link    = pred[rbd_pkg::VAL_W-1:0];
        r.succ_link    = succ[rbd_pkg::VAL_W-1:0];
        r.status       = st;
        awaited_items.insert(awaited_items.size(), r);
    endfunction

    function automatic void next_record(input int unsigned nxt, input int unsigned sz);
        if (recs_left == 0)
            parse_phase = rbd_pkg::PH_IDLE;
        else if (nxt + LENGTH_CHARS > sz)
        begin
            blk_status  = rbd_pkg::ST_TRUNC;
            parse_phase = rbd_pkg::PH_ERR;
        end
        else
        begin
            parse_phase = rbd_pkg::PH_LEN;
            begin_field();
        end
    endfunction

    function automatic void reset_block();
        byte_pos    = 0;
        parse_phase = rbd_pkg::PH_COUNT;
        begin_field();
        recs_left   = 0;
        text_left   = 0;
        blk_status  = rbd_pkg::ST_OK;
    endfunction

    function automatic void reset_all();
        blk_size  = 13'(SIZE_AT_RESET);
        hdr_count = 0;
        hdr_pred  = NULL_NUMBER;
        hdr_succ  = NULL_NUMBER;
        reset_block();
    endfunction

    // Works out the results that one accepted byte causes.
    function automatic void parse_byte(input logic [7:0] c);
        int unsigned sz;
        int unsigned nxt;
        int unsigned width;
        int          v;
        sz  = size_in_use();
        nxt = byte_pos + 1;
        case (parse_phase)
            rbd_pkg::PH_COUNT, rbd_pkg::PH_PRED, rbd_pkg::PH_SUCC, rbd_pkg::PH_LEN:
            begin
                width = (parse_phase == rbd_pkg::PH_COUNT) ? COUNT_CHARS
                      : (parse_phase == rbd_pkg::PH_LEN) ? LENGTH_CHARS : LINK_CHARS;
                scan_char(c);
                char_idx++;
                if (char_idx >= width)
                begin
                    v = field_number();
                    case (parse_phase)
                        rbd_pkg::PH_COUNT:
                        begin
                            hdr_count   = v;
                            parse_phase = rbd_pkg::PH_PRED;
                            begin_field();
                        end
                        rbd_pkg::PH_PRED:
                        begin
                            hdr_pred    = v;
                            parse_phase = rbd_pkg::PH_SUCC;
                            begin_field();
                        end
                        rbd_pkg::PH_SUCC:
                        begin
                            hdr_succ  = v;
                            recs_left = (hdr_count > 0) ? hdr_count : 0;
                            next_record(nxt, sz);
                        end
                        default:
                        begin
                            if (v < 0 || nxt + int'(v) > sz)
                            begin
                                blk_status  = rbd_pkg::ST_CORRUPT;
                                parse_phase = rbd_pkg::PH_ERR;
                            end
                            else if (v == 0)
                            begin
                                push_result(rbd_pkg::KIND_EMPTY, 8'h00, 1'b0, 0, 0, 0,
                                            rbd_pkg::ST_OK);
                                recs_left--;
                                next_record(nxt, sz);
                            end
                            else
                            begin
                                text_left   = v;
                                parse_phase = rbd_pkg::PH_TEXT;
                            end
                        end
                    endcase
                end
            end
            rbd_pkg::PH_TEXT:
            begin
                if (text_left > 0)
                    text_left--;
                push_result(rbd_pkg::KIND_BYTE, c, text_left == 0, 0, 0, 0,
                            rbd_pkg::ST_OK);
                if (text_left == 0)
                begin
                    if (recs_left > 0)
                        recs_left--;
                    next_record(nxt, sz);
                end
            end
            default:
                byte_pos = byte_pos;
        endcase

        if (nxt >= sz)
        begin
            push_result(rbd_pkg::KIND_STATUS, 8'h00, 1'b0, hdr_count, hdr_pred, hdr_succ,
                        blk_status);
            reset_block();
        end
        else
            byte_pos = nxt;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    function automatic void compare_result();
        rbd_pkg::result_t want;
        if (awaited_items.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual kind %0d tdata 0x%0h",
                     $time, m_tuser, m_tdata);
            return;
        end
        want = awaited_items.pop_front();
        check_field("kind",         want.kind,         m_tuser);
        check_field("data_byte",    want.data_byte,    m_tdata[7:0]);
        check_field("record_last",  want.record_last,  m_tlast);
        check_field("record_count", want.record_count, m_tdata[22:8]);
        check_field("pred_link",    want.pred_link,    m_tdata[50:23]);
        check_field("succ_link",    want.succ_link,    m_tdata[78:51]);
        check_field("status",       want.status,       m_tdata[80:79]);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_all();
            awaited_items.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                blk_size = cfg_data;
            if (s_tvalid && s_tready)
                parse_byte(s_tdata);
            if (m_tvalid && m_tready)
                compare_result();
        end
        outstanding = awaited_items.size();
    end

endmodule

// ===== tb/record_block_deframer_tb.sv =====
// ============================================================================
// record_block_deframer_tb: stimulus and verdict for the record deframer
// Streams whole blocks through the deframer: a few hand-written blocks for the
// header, length and error corner cases, then random blocks that are mostly
// well-formed with random content, some broken and some pure noise, over a
// series of block sizes. A separate check module predicts and compares.
// ============================================================================
module record_block_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 8;
    // Settling margin for the input register and result queue before a register write.
    localparam int SETTLE_CYCLES   = 8;
    localparam int IDLE_PERCENT    = 26;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_BYTES    = 1500;
    localparam int CYCLE_LIMIT     = 400000;

    localparam int COUNT_CHARS     = 4;
    localparam int LINK_CHARS      = 8;
    localparam int LENGTH_CHARS    = 4;
    localparam int HEADER_BYTES    = COUNT_CHARS + 2 * LINK_CHARS;
    localparam int MAX_BLOCK_BYTES = 4096;

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] LOWER_A = 8'h61;

    // Ways of writing a number into a fixed-width ASCII field.
    typedef enum int {
        FMT_SPACES,   // right-justified, padded with spaces
        FMT_ZEROS,    // right-justified, padded with zeros after the sign
        FMT_LEFT,     // left-justified, followed by non-digit filler
        FMT_PLUS,     // explicit plus sign on non-negative values
        FMT_WS        // padded with mixed white space characters
    } num_style_t;

    typedef enum int {
        BLK_CLEAN,    // consistent header and records
        BLK_BROKEN,   // bad count or a bad length prefix somewhere
        BLK_NOISE     // random bytes, biased toward number characters
    } blk_flavor_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data  = 13'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          mismatches;
    int          outstanding;

    // Bytes of the block that is being sent next, padding included.
    logic [7:0]  block_bytes[$];
    int          cur_size = 512;

    logic        sender_steady   = 1'b0;
    logic        receiver_steady = 1'b0;
    logic        hold_request    = 1'b0;
    int          hold_left       = 0;
    int unsigned cycle_count     = 0;

    string       noise_chars = "0123456789 +-F";

    record_block_deframer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    record_block_deframer_check result_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver. It normally stalls at random; a hold request makes it refuse
    // every result for a long stretch, counted here, so that the result queue
    // fills and the deframer has to stall its byte input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (receiver_steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Offers one byte, idling at random first, and returns at the edge where
    // the transaction completes. Valid stays high so that back-to-back bytes
    // need no gap.
    task automatic send_byte(input logic [7:0] b);
        while (!sender_steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_block();
        foreach (block_bytes[i])
            send_byte(block_bytes[i]);
    endtask

    // Stops offering bytes, waits until every predicted result has been seen,
    // then lets the pipeline settle in case the last bytes caused no result.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Block size changes only happen with the deframer drained.
    task automatic write_size(input int value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value[12:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_size  = (value > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES
                  : (value < HEADER_BYTES) ? HEADER_BYTES : value;
    endtask

    // Appends one byte to the block under construction.
    function automatic void add_byte(input logic [7:0] b);
        block_bytes.insert(block_bytes.size(), b);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? rbd_pkg::CHAR_SPACE : rbd_pkg::CHAR_TAB + 8'(r);
    endfunction

    // Writes a number into a field of the given width. Callers keep the value
    // short enough for the width; a plus sign is dropped where it won't fit.
    task automatic add_number(input int value, input int width, input num_style_t style);
        string body;
        logic  plus;
        int    pad;
        int    r;
        body = $sformatf("%0d", (value < 0) ? -value : value);
        plus = (style == FMT_PLUS) && (value >= 0) && (body.len() < width);
        pad  = width - body.len() - ((value < 0 || plus) ? 1 : 0);
        if (style == FMT_ZEROS || style == FMT_LEFT)
        begin
            if (value < 0)
                add_byte(rbd_pkg::CHAR_MINUS);
        end
        if (style == FMT_ZEROS)
            repeat (pad) add_byte(rbd_pkg::CHAR_ZERO);
        else if (style != FMT_LEFT)
        begin
            repeat (pad) add_byte((style == FMT_WS) ? blank_char() : rbd_pkg::CHAR_SPACE);
            if (value < 0)
                add_byte(rbd_pkg::CHAR_MINUS);
            else if (plus)
                add_byte(rbd_pkg::CHAR_PLUS);
        end
        add_text(body);
        // Left-justified numbers end in filler: spaces, letters or an F run,
        // none of which may change the decoded value.
        if (style == FMT_LEFT)
        begin
            repeat (pad)
            begin
                r = $urandom_range(0, 2);
                add_byte((r == 0) ? rbd_pkg::CHAR_SPACE : (r == 1) ? rbd_pkg::CHAR_F
                         : LOWER_A + 8'($urandom_range(0, 25)));
            end
        end
    endtask

    // A field that has no digit where a number should start.
    task automatic add_junk(input int width);
        add_byte(UPPER_A + 8'($urandom_range(0, 25)));
        repeat (width - 1) add_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic add_field(input int width, input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            repeat (width) add_byte(rbd_pkg::CHAR_F);
        else if (r < 13)
            add_junk(width);
        else
            add_number(lo + int'($urandom_range(0, hi - lo)), width,
                       num_style_t'($urandom_range(0, 4)));
    endtask

    // Builds one block of exactly 'size' bytes into block_bytes.
    task automatic build_block(input int size, input blk_flavor_t flavor,
                               input int max_records, input int max_text);
        int   n;
        int   room;
        int   len;
        int   lim;
        logic bad;
        block_bytes.delete();
        if (flavor == BLK_NOISE)
        begin
            repeat (size)
            begin
                if ($urandom_range(0, 1))
                    add_byte(8'($urandom_range(0, 255)));
                else
                    add_byte(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
            end
            return;
        end

        // Header. A broken block may claim a count that the records do not
        // match, so the parser runs into padding or the block end.
        n = $urandom_range(0, max_records);
        if (flavor == BLK_BROKEN && $urandom_range(0, 2) == 0)
            add_field(COUNT_CHARS, -999, 9999);
        else
            add_number(n + ((flavor == BLK_BROKEN) ? int'($urandom_range(0, 3)) : 0),
                       COUNT_CHARS, num_style_t'($urandom_range(0, 4)));
        add_field(LINK_CHARS, -9999999, 99999999);
        add_field(LINK_CHARS, -9999999, 99999999);

        room = size - HEADER_BYTES;
        for (int i = 0; i < n && room >= LENGTH_CHARS; i++)
        begin
            bad = (flavor == BLK_BROKEN) && ($urandom_range(0, 3) == 0);
            if (bad)
            begin
                // Length that runs past the block end, negative, null or
                // unreadable; the rest of the block is then filler.
                case ($urandom_range(0, 3))
                    0: add_number(room - LENGTH_CHARS + 1 + int'($urandom_range(0, 9)),
                                  LENGTH_CHARS, num_style_t'($urandom_range(0, 4)));
                    1: add_number(-int'($urandom_range(1, 999)), LENGTH_CHARS,
                                  num_style_t'($urandom_range(0, 4)));
                    2: repeat (LENGTH_CHARS) add_byte(rbd_pkg::CHAR_F);
                    default: add_junk(LENGTH_CHARS);
                endcase
                room -= LENGTH_CHARS;
                break;
            end
            lim = (room - LENGTH_CHARS < max_text) ? room - LENGTH_CHARS : max_text;
            len = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, lim));
            add_number(len, LENGTH_CHARS, num_style_t'($urandom_range(0, 4)));
            repeat (len) add_byte(8'($urandom_range(0, 255)));
            room -= LENGTH_CHARS + len;
        end
        while (block_bytes.size() < size)
            add_byte($urandom_range(0, 1) ? rbd_pkg::CHAR_SPACE
                     : 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int          phase_no;
        int          blocks;
        int          size;
        int          r;
        int          random_sent;
        blk_flavor_t flavor;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ------------------------------------------------------------------
        // Directed blocks.
        // ------------------------------------------------------------------

        // A size below the header length saturates to the header length.
        // Count zero, null predecessor, most negative successor.
        write_size(3);
        block_bytes.delete();
        add_text("   0FFFFFFFF-9999999");
        send_block();

        // Count with a plus sign and a trailing letter, largest predecessor,
        // successor with no digits. Two records are due but no length prefix
        // fits, so the status reports a truncated prefix.
        block_bytes.delete();
        add_text(" +2a99999999  x1    ");
        send_block();

        // An empty record whose length ends on the block's last byte: the
        // marker and the status item come from the same byte.
        write_size(24);
        block_bytes.delete();
        add_text("000100000000   +7   0000");
        send_block();

        // Negative length after white space in the links: corrupt length,
        // and the text that follows is consumed without any result.
        write_size(40);
        block_bytes.delete();
        add_text("   3FFFFFFFF\t\t\t\t-005  -1");
        repeat (16) add_byte(8'($urandom_range(0, 255)));
        send_block();

        // Largest register value saturates to the maximum block. One short
        // record, then padding. The size then drops below the current
        // position, so the next byte ends the block.
        write_size(13'h1FFF);
        block_bytes.delete();
        add_text("   100000002   +31410002hiPAD!");
        send_block();
        write_size(22);
        block_bytes.delete();
        add_text("Z");
        send_block();

        // ------------------------------------------------------------------
        // Random blocks, in phases of one block size each.
        // ------------------------------------------------------------------
        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (phase_no == 0)
                size = 0;
            else if (phase_no == 2)
                size = 128;
            else if (r < 10)
                size = $urandom_range(0, HEADER_BYTES - 1);
            else if (r < 65)
                size = $urandom_range(HEADER_BYTES, 48);
            else
                size = $urandom_range(49, 130);
            write_size(size);

            // One phase runs with no idling on either side.
            sender_steady   <= (phase_no == 2);
            receiver_steady <= (phase_no == 2);
            blocks = (phase_no == 2) ? 6 : $urandom_range(2, 6);

            for (int b = 0; b < blocks && random_sent < RANDOM_BYTES; b++)
            begin
                // Long receiver hold-off while the sender keeps offering bytes.
                if ((phase_no == 1 || phase_no == 6) && b == 0)
                begin
                    hold_request <= 1'b1;
                    @(posedge clk);
                    hold_request <= 1'b0;
                end
                r = $urandom_range(0, 99);
                flavor = (r < 70) ? BLK_CLEAN : (r < 90) ? BLK_BROKEN : BLK_NOISE;
                build_block(cur_size, flavor, (cur_size > 60) ? 6 : 3, 12);
                send_block();
                random_sent += block_bytes.size();
            end
            phase_no++;
        end

        sender_steady   <= 1'b0;
        receiver_steady <= 1'b0;

        wait_quiet();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
